// ===== rtl/pert_pkg.sv =====
`timescale 1ns / 1ps
// package for the priority expiry record table
// record type, operation and status codes, controller states; no dependencies
package pert_pkg;

    localparam int TABLE_SLOTS_DEF = 32;

    typedef struct packed {
        logic        used;
        logic [31:0] handle;
        logic [7:0]  prio;
        logic [31:0] expiry;
    } rec_t;

    typedef enum logic [2:0] {
        FN_CLEAR  = 3'd0,
        FN_ADD    = 3'd1,
        FN_FIND   = 3'd2,
        FN_REMOVE = 3'd3,
        FN_SELECT = 3'd4,
        FN_PURGE  = 3'd5
    } func_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    localparam logic [1:0] REG_INVALID_HANDLE = 2'd0;
    localparam logic [1:0] REG_REPORT_DELETES = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

// ===== rtl/pert_cell.sv =====
`timescale 1ns / 1ps
// one record cell of the rotating table ring
// uses pert_pkg for the record type
module pert_cell
    import pert_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic shift_en,
    input  rec_t d,
    output rec_t q
);

    rec_t q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.used <= 1'b0;
        end else if (shift_en) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/priority_expiry_record_table_unit.sv =====
`timescale 1ns / 1ps
// priority expiry record table: records rotate through a ring of TABLE_SLOTS cells,
// the controller sees one record per cycle at the head cell while the output is not
// stalled. an item takes one pass of the ring and then the result state (a successful
// add takes a second pass to write the record in); one item at a time, a new item is
// accepted only in idle. the ring holds while any result waits on the output. reset
// empties every slot; registers return to defaults.
module priority_expiry_record_table_unit
    import pert_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [31:0] s_handle,
    input  logic [7:0]  s_priority_req,
    input  logic [31:0] s_expiration,
    input  logic [7:0]  s_min_priority,
    input  logic [31:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_out_handle,
    output logic [7:0]  m_out_priority,
    output logic [31:0] m_out_expiration,
    output logic [5:0]  m_purged_count,
    output logic        m_last_of_run
);

    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_SLOTS - 1);
    localparam logic [CW-1:0] ONE_IDX  = CW'(1);

    logic [31:0] inv_reg;
    logic        rep_reg;

    state_t      state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] k_reg, k_next;
    logic        free_reg, free_next;
    logic        hit_reg, hit_next;
    logic [5:0]  pcnt_reg, pcnt_next;
    rec_t        res_reg, res_next;

    logic [2:0]  fn_reg;
    logic [31:0] h_reg, e_reg, now_reg;
    logic [7:0]  p_reg, minp_reg;

    logic        mv_reg;
    logic [2:0]  mst_reg;
    logic [31:0] mh_reg, me_reg;
    logic [7:0]  mp_reg;
    logic [5:0]  mc_reg;
    logic        ml_reg;

    rec_t cell_q [TABLE_SLOTS];
    rec_t feed;
    rec_t head;
    logic shift_en;
    logic out_busy;
    logic emit_del;
    logic emit_fin;
    logic [2:0] fin_status;
    rec_t fin_rec;
    logic [5:0] fin_cnt;
    logic match, expired, better;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_SLOTS; gi++) begin : g_ring
            if (gi == TABLE_SLOTS - 1) begin : g_tail
                pert_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift_en(shift_en),
                    .d(feed), .q(cell_q[gi])
                );
            end else begin : g_mid
                pert_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift_en(shift_en),
                    .d(cell_q[gi+1]), .q(cell_q[gi])
                );
            end
        end
    endgenerate

    assign head     = cell_q[0];
    assign out_busy = mv_reg && !m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    assign match   = head.used && (head.handle == h_reg) && (h_reg != inv_reg);
    assign expired = head.used && (head.expiry != 32'd0) && (head.expiry <= now_reg);
    assign better  = head.used && (head.prio >= minp_reg) &&
                     (!hit_reg || (head.prio > res_reg.prio) ||
                      ((head.prio == res_reg.prio) && (head.expiry < res_reg.expiry)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg <= 32'd0;
            rep_reg <= 1'b1;
        end else if (cfg_we) begin
            if (cfg_index == REG_INVALID_HANDLE) inv_reg <= cfg_wdata;
            if (cfg_index == REG_REPORT_DELETES) rep_reg <= cfg_wdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            fn_reg   <= s_func;
            h_reg    <= s_handle;
            p_reg    <= s_priority_req;
            e_reg    <= s_expiration;
            minp_reg <= s_min_priority;
            now_reg  <= s_now_time;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        free_next  = free_reg;
        hit_next   = hit_reg;
        pcnt_next  = pcnt_reg;
        res_next   = res_reg;
        feed       = head;
        shift_en   = 1'b0;
        emit_del   = 1'b0;
        emit_fin   = 1'b0;
        fin_status = ST_OK;
        fin_rec    = '0;
        fin_cnt    = 6'd0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                    free_next  = 1'b0;
                    hit_next   = 1'b0;
                    pcnt_next  = 6'd0;
                    res_next   = '0;
                end
            end
            S_SCAN: begin
                if (!out_busy) begin
                    shift_en = 1'b1;
                    case (fn_reg)
                        FN_CLEAR: feed.used = 1'b0;
                        FN_ADD: begin
                            if (!head.used && !free_reg) begin
                                free_next = 1'b1;
                                k_next    = cnt_reg;
                            end
                            if (match) hit_next = 1'b1;
                        end
                        FN_FIND, FN_REMOVE: begin
                            if (match && !hit_reg) begin
                                hit_next = 1'b1;
                                res_next = head;
                                if (fn_reg == FN_REMOVE) feed.used = 1'b0;
                            end
                        end
                        FN_SELECT: begin
                            if (better) begin
                                hit_next = 1'b1;
                                res_next = head;
                            end
                        end
                        FN_PURGE: begin
                            if (expired) begin
                                feed.used = 1'b0;
                                pcnt_next = pcnt_reg + 6'd1;
                                emit_del  = rep_reg;
                            end
                        end
                        default: ;
                    endcase
                    cnt_next = cnt_reg + ONE_IDX;
                    if (cnt_reg == LAST_IDX) begin
                        cnt_next = '0;
                        // successful add needs a second pass to drop the record in
                        if (fn_reg == FN_ADD && free_next && !hit_next)
                            state_next = S_WRITE;
                        else
                            state_next = S_DONE;
                    end
                end
            end
            S_WRITE: begin
                if (!out_busy) begin
                    shift_en = 1'b1;
                    if (cnt_reg == k_reg) begin
                        feed.used   = 1'b1;
                        feed.handle = h_reg;
                        feed.prio   = p_reg;
                        feed.expiry = e_reg;
                    end
                    cnt_next = cnt_reg + ONE_IDX;
                    if (cnt_reg == LAST_IDX) begin
                        cnt_next   = '0;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                case (fn_reg)
                    FN_ADD: begin
                        if (!free_reg)    fin_status = ST_FULL;
                        else if (hit_reg) fin_status = ST_DUP;
                        else begin
                            fin_rec.handle = h_reg;
                            fin_rec.prio   = p_reg;
                            fin_rec.expiry = e_reg;
                        end
                    end
                    FN_FIND, FN_REMOVE: begin
                        if (h_reg == inv_reg) fin_status = ST_INVALID;
                        else if (!hit_reg)    fin_status = ST_NOTFOUND;
                        else                  fin_rec = res_reg;
                    end
                    FN_SELECT: begin
                        if (!hit_reg) fin_status = ST_NOTFOUND;
                        else          fin_rec = res_reg;
                    end
                    FN_PURGE: fin_cnt = pcnt_reg;
                    default: ;
                endcase
                if (!out_busy) begin
                    emit_fin   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        k_reg    <= k_next;
        free_reg <= free_next;
        hit_reg  <= hit_next;
        pcnt_reg <= pcnt_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (emit_del || emit_fin) begin
            mv_reg <= 1'b1;
        end else if (m_ready) begin
            mv_reg <= 1'b0;
        end
        if (emit_del) begin
            mst_reg <= ST_OK;
            mh_reg  <= head.handle;
            mp_reg  <= 8'd0;
            me_reg  <= 32'd0;
            mc_reg  <= 6'd0;
            ml_reg  <= 1'b0;
        end else if (emit_fin) begin
            mst_reg <= fin_status;
            mh_reg  <= fin_rec.handle;
            mp_reg  <= fin_rec.prio;
            me_reg  <= fin_rec.expiry;
            mc_reg  <= fin_cnt;
            ml_reg  <= 1'b1;
        end
    end

    assign m_valid          = mv_reg;
    assign m_status         = mst_reg;
    assign m_out_handle     = mh_reg;
    assign m_out_priority   = mp_reg;
    assign m_out_expiration = me_reg;
    assign m_purged_count   = mc_reg;
    assign m_last_of_run    = ml_reg;

    // the ring never moves while a result is stuck on the output
    a_hold_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |-> !shift_en)
        else $error("ring shifted under output stall");

    // the final result of an item carries the last flag
    a_fin_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fin |=> (mv_reg && ml_reg))
        else $error("final result without last flag");

    // delete results only come out of a purge scan
    a_del_purge: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_del |-> (state_reg == S_SCAN && fn_reg == FN_PURGE && rep_reg))
        else $error("delete result outside purge");

    // a pass ends at the last slot and goes on to the result or write pass
    a_pass_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && shift_en && cnt_reg == LAST_IDX)
        |=> (state_reg == S_DONE || state_reg == S_WRITE) && cnt_reg == '0)
        else $error("scan pass did not wrap");

endmodule
